// ===== hw/rtl/sdc_pkg.sv =====
// shared types and constants for the strided dilated 1-d convolution block
package sdc_pkg;

    localparam int ACC_W = 40;
    // signed width of the running sample index
    localparam int E_W   = 22;

    // request codes
    localparam logic [1:0] FUNC_LOAD_COEF   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE     = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_TAPS_USED     = 3'd0;
    localparam logic [2:0] REG_SAMPLE_COUNT  = 3'd1;
    localparam logic [2:0] REG_FRAME_COUNT   = 3'd2;
    localparam logic [2:0] REG_CENTER_OFFSET = 3'd3;
    localparam logic [2:0] REG_STEP_SIZE     = 3'd4;
    localparam logic [2:0] REG_DILATION      = 3'd5;
    localparam logic [2:0] REG_COMPLEX_MODE  = 3'd6;

    // partial product phases of one complex tap
    localparam logic [1:0] PH_RR = 2'd0;
    localparam logic [1:0] PH_II = 2'd1;
    localparam logic [1:0] PH_RI = 2'd2;
    localparam logic [1:0] PH_IR = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [11:0]        position;
        logic signed [15:0] value_re;
        logic signed [15:0] value_im;
    } req_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_re;
        logic signed [ACC_W-1:0] acc_im;
        logic                    frame_outside;
    } rsp_item_t;

endpackage

// ===== hw/rtl/strided_dilated_conv1d_top.sv =====
// strided dilated 1-d convolution engine with loadable kernel and signal
//
// req channel carries one item per request: func selects load coefficient,
// load sample or compute frame, position gives the index. loads write one
// memory entry and produce no rsp item; a compute request produces exactly
// one rsp item with the full precision 40-bit frame sum.
// cfg port: registers are written by cfg_wr_en/cfg_index/cfg_data; the user
// writes them only while idle, the block itself does not enforce it. loads
// are taken one per cycle while no compute runs. a compute request walks the
// taps through one shared multiplier: each tap passes an address state, then
// the multiply state for one partial product (four in complex mode, just one
// and adding nothing when the sample lies outside the signal). req_stall is
// high while a compute runs; a frame at or beyond frame_count skips the taps.
// the rsp register holds a finished item while rsp_stall is high; loads are
// still taken then, a further compute waits at its end until the register
// frees up. reset clears the registers to their defaults and empties the
// rsp register; the coefficient and sample memories are not cleared.
module strided_dilated_conv1d_top #(
    parameter int MAX_TAPS    = 64,
    parameter int MAX_SAMPLES = 4096,
    parameter int DATA_WIDTH  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  sdc_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sdc_pkg::rsp_item_t rsp_item,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_data
);
    import sdc_pkg::*;

    localparam int COEF_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SAMP_AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int PROD_W  = 2 * DATA_WIDTH;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_ADDR  = 6'b000100,
        S_MUL   = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // configuration
    logic [6:0]         taps_used_reg;
    logic [12:0]        sample_count_reg;
    logic [12:0]        frame_count_reg;
    logic signed [12:0] center_offset_reg;
    logic [7:0]         step_size_reg;
    logic [7:0]         dilation_reg;
    logic               complex_mode_reg;

    // memories, entries are {im, re}
    logic [PROD_W-1:0] coef_mem [MAX_TAPS];
    logic [PROD_W-1:0] samp_mem [MAX_SAMPLES];
    logic [PROD_W-1:0] coef_rd_reg;
    logic [PROD_W-1:0] samp_rd_reg;

    state_t state_reg, state_next;
    logic [11:0]             pos_reg, pos_next;
    logic signed [E_W-1:0]   n_reg, n_next;
    logic [6:0]              k_reg, k_next;
    logic [1:0]              phase_reg, phase_next;
    logic                    in_range_reg, in_range_next;
    logic                    last_reg, last_next;
    logic                    outside_reg, outside_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                    prod_vld_reg, prod_vld_next;
    logic [1:0]              prod_sel_reg;
    logic signed [ACC_W-1:0] acc_re_reg, acc_re_next;
    logic signed [ACC_W-1:0] acc_im_reg, acc_im_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_item_t               rsp_item_reg;

    logic                    req_take;
    logic                    rsp_free;
    logic [6:0]              taps_eff;
    logic [12:0]             len_eff;
    logic [13:0]             dil_half;
    logic [19:0]             pos_step;
    logic                    n_in_range;
    logic                    tap_done;
    logic signed [DATA_WIDTH-1:0] ld_re, ld_im;
    logic signed [DATA_WIDTH-1:0] h_re, h_im, x_re, x_im;
    logic signed [DATA_WIDTH-1:0] mul_a, mul_b;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    assign taps_eff = (32'(taps_used_reg) > 32'(MAX_TAPS)) ? 7'(MAX_TAPS) : taps_used_reg;
    assign len_eff  = (32'(sample_count_reg) > 32'(MAX_SAMPLES)) ?
                      13'(MAX_SAMPLES) : sample_count_reg;
    assign dil_half = 14'(dilation_reg * taps_eff[6:1]);
    assign pos_step = 20'(pos_reg * step_size_reg);
    assign n_in_range = !n_reg[E_W-1] && ($unsigned(n_reg) < E_W'(len_eff));

    // loaded values wrap to the stored data width
    assign ld_re = DATA_WIDTH'(req_item.value_re);
    assign ld_im = DATA_WIDTH'(req_item.value_im);

    assign h_re = coef_rd_reg[DATA_WIDTH-1:0];
    assign h_im = coef_rd_reg[PROD_W-1:DATA_WIDTH];
    assign x_re = samp_rd_reg[DATA_WIDTH-1:0];
    assign x_im = samp_rd_reg[PROD_W-1:DATA_WIDTH];
    assign mul_a = (phase_reg == PH_RR || phase_reg == PH_RI) ? h_re : h_im;
    assign mul_b = (phase_reg == PH_RR || phase_reg == PH_IR) ? x_re : x_im;

    assign tap_done = !in_range_reg || !complex_mode_reg || (phase_reg == PH_IR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_used_reg     <= 7'd1;
            sample_count_reg  <= 13'd1;
            frame_count_reg   <= 13'd0;
            center_offset_reg <= 13'sd0;
            step_size_reg     <= 8'd1;
            dilation_reg      <= 8'd1;
            complex_mode_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TAPS_USED:     taps_used_reg     <= cfg_data[6:0];
                REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data;
                REG_FRAME_COUNT:   frame_count_reg   <= cfg_data;
                REG_CENTER_OFFSET: center_offset_reg <= $signed(cfg_data);
                REG_STEP_SIZE:     step_size_reg     <= cfg_data[7:0];
                REG_DILATION:      dilation_reg      <= cfg_data[7:0];
                REG_COMPLEX_MODE:  complex_mode_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take && req_item.func == FUNC_LOAD_COEF &&
            32'(req_item.position) < 32'(MAX_TAPS))
        begin
            coef_mem[COEF_AW'(req_item.position)] <= {ld_im, ld_re};
        end
        if (state_reg == S_ADDR)
        begin
            coef_rd_reg <= coef_mem[COEF_AW'(k_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take && req_item.func == FUNC_LOAD_SAMPLE &&
            32'(req_item.position) < 32'(MAX_SAMPLES))
        begin
            samp_mem[SAMP_AW'(req_item.position)] <= {ld_im, ld_re};
        end
        if (state_reg == S_ADDR)
        begin
            samp_rd_reg <= samp_mem[n_reg[SAMP_AW-1:0]];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        in_range_next  = in_range_reg;
        last_next      = last_reg;
        outside_next   = outside_reg;
        prod_vld_next  = 1'b0;
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        // accumulate the product from the previous cycle
        if (prod_vld_reg)
        begin
            case (prod_sel_reg)
                PH_RR:   acc_re_next = acc_re_reg + ACC_W'(prod_reg);
                PH_II:   acc_re_next = acc_re_reg - ACC_W'(prod_reg);
                PH_RI:   acc_im_next = acc_im_reg + ACC_W'(prod_reg);
                PH_IR:   acc_im_next = acc_im_reg + ACC_W'(prod_reg);
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_take && req_item.func == FUNC_COMPUTE)
                begin
                    pos_next     = req_item.position;
                    acc_re_next  = '0;
                    acc_im_next  = '0;
                    outside_next = (13'(req_item.position) >= frame_count_reg);
                    state_next   = outside_next ? S_DONE : S_SETUP;
                end
            end
            S_SETUP:
            begin
                // end sample of the frame
                n_next = E_W'(center_offset_reg) + $signed(E_W'(dil_half))
                         + $signed(E_W'(pos_step));
                k_next = '0;
                state_next = (taps_eff == 7'd0) ? S_DRAIN : S_ADDR;
            end
            S_ADDR:
            begin
                in_range_next = n_in_range;
                last_next     = (k_reg == taps_eff - 7'd1);
                n_next        = n_reg - $signed(E_W'(dilation_reg));
                k_next        = k_reg + 7'd1;
                phase_next    = PH_RR;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                prod_vld_next = in_range_reg;
                if (tap_done)
                begin
                    state_next = last_reg ? S_DRAIN : S_ADDR;
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prod_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prod_vld_reg  <= prod_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        phase_reg    <= phase_next;
        in_range_reg <= in_range_next;
        last_reg     <= last_next;
        outside_reg  <= outside_next;
        acc_re_reg   <= acc_re_next;
        acc_im_reg   <= acc_im_next;
        if (state_reg == S_MUL)
        begin
            prod_reg     <= mul_a * mul_b;
            prod_sel_reg <= phase_reg;
        end
        if (state_reg == S_DONE && rsp_free)
        begin
            rsp_item_reg.acc_re        <= acc_re_reg;
            rsp_item_reg.acc_im        <= acc_im_reg;
            rsp_item_reg.frame_outside <= outside_reg;
        end
    end

    // an outside frame always carries a zero sum
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.frame_outside |->
            rsp_item.acc_re == '0 && rsp_item.acc_im == '0)
        else $error("outside frame with nonzero sum");

    // real mode never touches the imaginary sum
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !complex_mode_reg |-> rsp_item.acc_im == '0)
        else $error("imaginary sum nonzero in real mode");

    // tap counter stays inside the kernel
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADDR |-> k_reg < taps_eff)
        else $error("tap index beyond taps in use");

    // a product only follows a multiply cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> $past(state_reg == S_MUL))
        else $error("product without multiply cycle");

endmodule
